@@ design/postfix_expression_evaluator_unit_defines.svh @@
// Assertion macros for the postfix expression evaluator.
// Used by the checker; no dependencies of its own.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RPN_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RPN_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/rpn_pkg.sv @@
// Shared types, character codes and error codes of the postfix evaluator.
// No dependencies.
package rpn_pkg;

   typedef logic [31:0] word_type;
   typedef logic [1:0]  err_type;

   localparam int RPN_STACK_DEPTH = 128;

   // Character codes
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_MUL  = 8'h2A;
   localparam logic [7:0] CH_ADD  = 8'h2B;
   localparam logic [7:0] CH_SUB  = 8'h2D;
   localparam logic [7:0] CH_DIV  = 8'h2F;
   localparam logic [7:0] CH_MOD  = 8'h25;
   localparam logic [7:0] CH_POW  = 8'h5E;
   localparam logic [7:0] CH_GT   = 8'h3E;
   localparam logic [7:0] CH_LT   = 8'h3C;
   localparam logic [7:0] CH_EQ   = 8'h3D;
   localparam logic [7:0] CH_AND  = 8'h26;
   localparam logic [7:0] CH_OR   = 8'h7C;

   // Error codes
   localparam err_type ERR_NONE  = 2'd0;
   localparam err_type ERR_UNDER = 2'd1;
   localparam err_type ERR_OVER  = 2'd2;
   localparam err_type ERR_DIV0  = 2'd3;

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CH_MUL) || (c == CH_ADD) || (c == CH_SUB) || (c == CH_DIV) ||
             (c == CH_MOD) || (c == CH_POW) || (c == CH_GT)  || (c == CH_LT)  ||
             (c == CH_EQ)  || (c == CH_AND) || (c == CH_OR);
   endfunction

   function automatic word_type magnitude(input word_type x);
      return x[31] ? (32'd0 - x) : x;
   endfunction

endpackage

@@ design/rpn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/postfix_expression_evaluator_unit.sv @@
// Postfix (reverse Polish) expression evaluator on a 32-bit integer stack.
// Input channel req_*: one character word per handshake, req_end_of_expr marks the
// last character. Result channel rsp_*: one word per expression, the top of stack
// and the first error seen (0 ok, 1 underflow, 2 overflow, 3 divide by zero).
// The block takes one character at a time and holds req_stall high while it works:
//   digit or other non-operator character : pushed onto the stack
//   + - * > < = & |                        : two operands popped, result pushed
//   / and %                                : 32-step restoring divider
//   ^                                      : square and multiply over the exponent bits
// The end-of-expression character adds a stack read of the top.
// The stack RAM does one read per cycle; the shared multiplier and divider
// step one bit or one product per cycle.
// The result sits in an output register; the block accepts the next character
// while rsp_stall holds that result, and only waits if a second result is ready
// before the first one is taken.
// Reset clears the stack count, the error and the output valid at once; no
// clearing pass is needed.
module postfix_expression_evaluator_unit import rpn_pkg::*; #(
   parameter int STACK_DEPTH = RPN_STACK_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_end_of_expr,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic [1:0]         rsp_error_code
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [4:0] DIV_LAST_STEP = 5'd31;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LDB   = 4'd1;
   localparam logic [3:0] S_LDA   = 4'd2;
   localparam logic [3:0] S_EXEC  = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_DIVF  = 4'd5;
   localparam logic [3:0] S_POWM  = 4'd6;
   localparam logic [3:0] S_POWS  = 4'd7;
   localparam logic [3:0] S_PUSH  = 4'd8;
   localparam logic [3:0] S_TOPRD = 4'd9;
   localparam logic [3:0] S_TOP   = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   err_type       error_ff, error_in;
   logic [7:0]    char_ff, char_in;
   logic          last_ff, last_in;
   word_type      a_ff, a_in;
   word_type      b_ff, b_in;
   word_type      acc_ff, acc_in;
   logic          neg_ff, neg_in;
   logic [4:0]    step_ff, step_in;
   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_value_ff, rsp_value_in;
   err_type       rsp_error_ff, rsp_error_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   word_type      ram_rdata;

   logic [CW-1:0] cnt_m1, cnt_m2;
   word_type      mul_x, mul_y, mul_p;
   logic [32:0]   div_sh, div_diff;
   logic          div_ge;
   word_type      div_q;

   rpn_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH)
   ) u_rpn_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (acc_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign cnt_m1 = count_ff - CW'(1);
   assign cnt_m2 = count_ff - CW'(2);

   // Shared multiplier: operand select by sequencer step, low 32 bits kept
   always_comb begin
      if (state_ff == S_POWS) begin
         mul_x = a_ff;
         mul_y = a_ff;
      end else if (state_ff == S_POWM) begin
         mul_x = acc_ff;
         mul_y = a_ff;
      end else begin
         mul_x = a_ff;
         mul_y = b_ff;
      end
   end
   assign mul_p = mul_x * mul_y;

   // Restoring divider step: remainder in acc, quotient shifts into a
   assign div_sh   = {acc_ff, a_ff[31]};
   assign div_diff = div_sh - {1'b0, b_ff};
   assign div_ge   = ~div_diff[32];
   assign div_q    = (char_ff == CH_DIV) ? a_ff : acc_ff;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_raddr    = cnt_m1[AW-1:0];

      // drop the result word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               char_in = req_char_code;
               last_in = req_end_of_expr;
               if (is_operator(req_char_code)) begin
                  ram_re   = 1'b1;
                  ram_raddr = cnt_m1[AW-1:0];
                  state_in = S_LDB;
               end else begin
                  acc_in   = {24'd0, req_char_code} - {24'd0, CH_ZERO};
                  state_in = S_PUSH;
               end
            end
         end
         S_LDB: begin
            b_in      = (count_ff != '0) ? ram_rdata : '0;
            ram_re    = 1'b1;
            ram_raddr = cnt_m2[AW-1:0];
            state_in  = S_LDA;
         end
         S_LDA: begin
            if (count_ff < CW'(2)) begin
               a_in     = '0;
               count_in = '0;
               if (error_in == ERR_NONE) error_in = ERR_UNDER;
            end else begin
               a_in     = ram_rdata;
               count_in = cnt_m2;
            end
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_PUSH;
            unique case (char_ff) inside
               CH_MUL: acc_in = mul_p;
               CH_ADD: acc_in = a_ff + b_ff;
               CH_SUB: acc_in = a_ff - b_ff;
               CH_DIV, CH_MOD: begin
                  if (b_ff == '0) begin
                     acc_in = '0;
                     if (error_in == ERR_NONE) error_in = ERR_DIV0;
                  end else begin
                     a_in     = magnitude(a_ff);
                     b_in     = magnitude(b_ff);
                     acc_in   = '0;
                     neg_in   = (char_ff == CH_DIV) ? (a_ff[31] ^ b_ff[31]) : a_ff[31];
                     step_in  = '0;
                     state_in = S_DIV;
                  end
               end
               CH_POW: begin
                  acc_in = 32'd1;
                  if (!b_ff[31]) begin
                     state_in = S_POWM;
                  end
               end
               CH_GT:  acc_in = {31'd0, $signed(a_ff) > $signed(b_ff)};
               CH_LT:  acc_in = {31'd0, $signed(a_ff) < $signed(b_ff)};
               CH_EQ:  acc_in = {31'd0, a_ff == b_ff};
               CH_AND: acc_in = {31'd0, (a_ff != '0) && (b_ff != '0)};
               default: acc_in = {31'd0, (a_ff != '0) || (b_ff != '0)};
            endcase
         end
         S_DIV: begin
            a_in    = {a_ff[30:0], div_ge};
            acc_in  = div_ge ? div_diff[31:0] : div_sh[31:0];
            step_in = step_ff + 5'd1;
            if (step_ff == DIV_LAST_STEP) begin
               state_in = S_DIVF;
            end
         end
         S_DIVF: begin
            acc_in   = neg_ff ? (32'd0 - div_q) : div_q;
            state_in = S_PUSH;
         end
         S_POWM: begin
            if (b_ff == '0) begin
               state_in = S_PUSH;
            end else begin
               if (b_ff[0]) acc_in = mul_p;
               state_in = S_POWS;
            end
         end
         S_POWS: begin
            a_in     = mul_p;
            b_in     = b_ff >> 1;
            state_in = S_POWM;
         end
         S_PUSH: begin
            if (count_ff == CW'(STACK_DEPTH)) begin
               if (error_in == ERR_NONE) error_in = ERR_OVER;
            end else begin
               ram_we   = 1'b1;
               count_in = count_ff + CW'(1);
            end
            state_in = last_ff ? S_TOPRD : S_IDLE;
         end
         S_TOPRD: begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m1[AW-1:0];
            state_in  = S_TOP;
         end
         S_TOP: begin
            // hold the top until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_value_in = '0;
                  rsp_error_in = (error_ff == ERR_NONE) ? ERR_UNDER : error_ff;
               end else begin
                  rsp_value_in = ram_rdata;
                  rsp_error_in = error_ff;
               end
               count_in = '0;
               error_in = ERR_NONE;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         error_ff     <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      last_ff      <= last_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      step_ff      <= step_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = $signed(rsp_value_ff);
   assign rsp_error_code = rsp_error_ff;

endmodule

@@ design/rpn_checker.sv @@
// Port-level assertions for the postfix expression evaluator, bound to the top.
// Depends on postfix_expression_evaluator_unit_defines.svh.
`include "postfix_expression_evaluator_unit_defines.svh"

module rpn_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [7:0]         req_char_code,
   input logic               req_end_of_expr,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_value,
   input logic [1:0]         rsp_error_code
);

   // No result word right after reset
   `RPN_ASSERT_ALWAYS(a_rst_no_rsp, reset |=> !rsp_valid, "result valid after reset")

   // An accepted character keeps the block busy in the next cycle
   `RPN_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall,
      "not busy after accept")

   // A new result appears as the block turns ready again
   `RPN_ASSERT(a_rsp_at_ready, $rose(rsp_valid) |-> !req_stall, "result while busy")

   // A stalled result word holds
   `RPN_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=>
      rsp_valid && $stable(rsp_value) && $stable(rsp_error_code), "stalled result changed")

   // A stalled character word holds
   `RPN_ASSERT(a_req_hold, req_valid && req_stall |=>
      req_valid && $stable(req_char_code) && $stable(req_end_of_expr), "stalled word changed")

endmodule

bind postfix_expression_evaluator_unit rpn_checker u_rpn_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_char_code   (req_char_code),
   .req_end_of_expr (req_end_of_expr),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_value       (rsp_value),
   .rsp_error_code  (rsp_error_code)
);
